### rtl/core/altet_pkg.sv
`timescale 1ns / 1ps

package altet_pkg;

  // fixed field widths of the item ports
  localparam int REQ_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 6;
  localparam int COUNT_W  = 7;

  // defaults for the top level parameters
  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // request codes
  localparam logic [REQ_W-1:0] REQ_SEARCH  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REVERSE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_UPDATE  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_DUMP    = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_DONE      = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_BAD_POS   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd5;

endpackage

### rtl/core/altet_ram.sv
`timescale 1ns / 1ps

module altet_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/altet_seq.sv
`timescale 1ns / 1ps

module altet_seq import altet_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [REQ_W-1:0]            req_type,
  input  logic signed [VALUE_W-1:0]   value,
  input  logic [POS_W-1:0]            position,
  output logic                        busy,
  output logic                        strobe,
  output logic [STATUS_W-1:0]         status,
  output logic [INDEX_W-1:0]          index,
  output logic signed [VALUE_W-1:0]   data,
  output logic                        last,
  output logic [COUNT_W-1:0]          count,
  output logic                        ram_we,
  output logic [$clog2(CAPACITY)-1:0] ram_waddr,
  output logic [DATA_WIDTH-1:0]       ram_wdata,
  output logic [$clog2(CAPACITY)-1:0] ram_raddr,
  input  logic [DATA_WIDTH-1:0]       ram_rdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam logic [COUNT_W-1:0] CAP = COUNT_W'(CAPACITY);
  localparam logic [COUNT_W-1:0] ONE = COUNT_W'(1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_WALK  = 6'b000010,
    ST_TAIL  = 6'b000100,
    ST_REV_A = 6'b001000,
    ST_REV_B = 6'b010000,
    ST_REV_C = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [REQ_W-1:0]      op, op_next;
  logic [DATA_WIDTH-1:0] key;
  logic [COUNT_W-1:0]    pos;
  logic [COUNT_W-1:0]    cnt, cnt_next;
  logic [COUNT_W-1:0]    fin, fin_next;
  logic [COUNT_W-1:0]    ridx, ridx_next;
  logic                  dir_up, dir_up_next;
  logic                  iss_done, iss_done_next;
  logic                  rvalid, rvalid_next;
  logic [COUNT_W-1:0]    rtag, rtag_next;
  logic [COUNT_W-1:0]    lo, lo_next;
  logic [COUNT_W-1:0]    hi, hi_next;
  logic [DATA_WIDTH-1:0] tmp, tmp_next;

  logic                      strobe_next;
  logic [STATUS_W-1:0]       status_next;
  logic [INDEX_W-1:0]        index_next;
  logic signed [VALUE_W-1:0] data_next;
  logic                      last_next;

  logic                      rd_issue;
  logic                      accept;
  logic signed [63:0]        val_ext;
  logic signed [63:0]        rd_ext;
  logic [DATA_WIDTH-1:0]     key_in;
  logic [DATA_WIDTH-1:0]     upd_word;
  logic [COUNT_W-1:0]        tag_up;
  logic [COUNT_W-1:0]        tag_dn;
  logic [COUNT_W-1:0]        cnt_m1;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;

  // key is sign extended, then cut to the stored word width
  assign val_ext = 64'(value);
  assign key_in  = val_ext[DATA_WIDTH-1:0];
  assign rd_ext  = 64'(signed'(ram_rdata));

  // even entries gain five, odd entries double
  assign upd_word = rtag[0] ? (ram_rdata << 1) : (ram_rdata + DATA_WIDTH'(5));
  assign tag_up   = rtag + ONE;
  assign tag_dn   = rtag - ONE;
  assign cnt_m1   = cnt - ONE;

  // request sequencer
  always_comb begin
    state_next    = state;
    op_next       = op;
    cnt_next      = cnt;
    fin_next      = fin;
    ridx_next     = ridx;
    dir_up_next   = dir_up;
    iss_done_next = iss_done;
    rvalid_next   = 1'b0;
    rtag_next     = rtag;
    lo_next       = lo;
    hi_next       = hi;
    tmp_next      = tmp;
    strobe_next   = 1'b0;
    status_next   = STAT_DONE;
    index_next    = '0;
    data_next     = '0;
    last_next     = 1'b1;
    rd_issue      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = ram_rdata;
    ram_raddr     = ridx[AW-1:0];

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          op_next = req_type;
          unique case (req_type)
            REQ_SEARCH: begin
              if (cnt == '0) begin
                strobe_next = 1'b1;
                status_next = STAT_NOT_FOUND;
              end else begin
                rd_issue      = 1'b1;
                ram_raddr     = '0;
                rvalid_next   = 1'b1;
                rtag_next     = '0;
                ridx_next     = ONE;
                dir_up_next   = 1'b1;
                fin_next      = cnt_m1;
                iss_done_next = (cnt_m1 == '0);
                state_next    = ST_WALK;
              end
            end
            REQ_INSERT: begin
              if (position > cnt) begin
                strobe_next = 1'b1;
                status_next = STAT_BAD_POS;
              end else if (cnt >= CAP) begin
                strobe_next = 1'b1;
                status_next = STAT_FULL;
              end else if (position == cnt) begin
                // append: no tail to move
                ram_we      = 1'b1;
                ram_waddr   = position[AW-1:0];
                ram_wdata   = key_in;
                cnt_next    = cnt + ONE;
                strobe_next = 1'b1;
              end else begin
                // move the tail up, highest entry first
                rd_issue      = 1'b1;
                ram_raddr     = cnt_m1[AW-1:0];
                rvalid_next   = 1'b1;
                rtag_next     = cnt_m1;
                ridx_next     = cnt_m1 - ONE;
                dir_up_next   = 1'b0;
                fin_next      = position;
                iss_done_next = (cnt_m1 == position);
                state_next    = ST_WALK;
              end
            end
            REQ_DELETE: begin
              if (position >= cnt) begin
                strobe_next = 1'b1;
                status_next = STAT_BAD_POS;
              end else if (position == cnt_m1) begin
                cnt_next    = cnt_m1;
                strobe_next = 1'b1;
              end else begin
                // move the tail down, lowest entry first
                rd_issue      = 1'b1;
                ram_raddr     = AW'(position + ONE);
                rvalid_next   = 1'b1;
                rtag_next     = position + ONE;
                ridx_next     = position + COUNT_W'(2);
                dir_up_next   = 1'b1;
                fin_next      = cnt_m1;
                iss_done_next = ((position + ONE) == cnt_m1);
                state_next    = ST_WALK;
              end
            end
            REQ_REVERSE: begin
              if (cnt <= ONE) begin
                strobe_next = 1'b1;
              end else begin
                rd_issue   = 1'b1;
                ram_raddr  = '0;
                lo_next    = '0;
                hi_next    = cnt_m1;
                state_next = ST_REV_A;
              end
            end
            REQ_UPDATE, REQ_DUMP: begin
              if (cnt == '0) begin
                strobe_next = 1'b1;
                status_next = (req_type == REQ_DUMP) ? STAT_EMPTY : STAT_DONE;
              end else begin
                rd_issue      = 1'b1;
                ram_raddr     = '0;
                rvalid_next   = 1'b1;
                rtag_next     = '0;
                ridx_next     = ONE;
                dir_up_next   = 1'b1;
                fin_next      = cnt_m1;
                iss_done_next = (cnt_m1 == '0);
                state_next    = ST_WALK;
              end
            end
            default: begin
              strobe_next = 1'b1;
            end
          endcase
        end
      end

      ST_WALK: begin
        // keep one read a cycle going until the final index is issued
        if (!iss_done) begin
          rd_issue      = 1'b1;
          ram_raddr     = ridx[AW-1:0];
          rvalid_next   = 1'b1;
          rtag_next     = ridx;
          ridx_next     = dir_up ? (ridx + ONE) : (ridx - ONE);
          iss_done_next = (ridx == fin);
        end
        // handle the word that comes back from the read issued the cycle before
        if (rvalid) begin
          unique case (op)
            REQ_SEARCH: begin
              if (ram_rdata == key) begin
                strobe_next = 1'b1;
                status_next = STAT_FOUND;
                index_next  = rtag[INDEX_W-1:0];
                state_next  = ST_IDLE;
              end else if (rtag == fin) begin
                strobe_next = 1'b1;
                status_next = STAT_NOT_FOUND;
                state_next  = ST_IDLE;
              end
            end
            REQ_INSERT: begin
              ram_we    = 1'b1;
              ram_waddr = tag_up[AW-1:0];
              if (rtag == fin) begin
                state_next = ST_TAIL;
              end
            end
            REQ_DELETE: begin
              ram_we    = 1'b1;
              ram_waddr = tag_dn[AW-1:0];
              if (rtag == fin) begin
                cnt_next    = cnt_m1;
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
              end
            end
            REQ_UPDATE: begin
              ram_we    = 1'b1;
              ram_waddr = rtag[AW-1:0];
              ram_wdata = upd_word;
              if (rtag == fin) begin
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
              end
            end
            default: begin
              // dump: one result per live entry
              strobe_next = 1'b1;
              index_next  = rtag[INDEX_W-1:0];
              data_next   = rd_ext[VALUE_W-1:0];
              last_next   = (rtag == fin);
              if (rtag == fin) begin
                state_next = ST_IDLE;
              end
            end
          endcase
        end
      end

      ST_TAIL: begin
        // new value into the freed slot
        ram_we      = 1'b1;
        ram_waddr   = pos[AW-1:0];
        ram_wdata   = key;
        cnt_next    = cnt + ONE;
        strobe_next = 1'b1;
        state_next  = ST_IDLE;
      end

      ST_REV_A: begin
        // low word arrives, fetch the high one
        tmp_next   = ram_rdata;
        rd_issue   = 1'b1;
        ram_raddr  = hi[AW-1:0];
        state_next = ST_REV_B;
      end

      ST_REV_B: begin
        ram_we     = 1'b1;
        ram_waddr  = lo[AW-1:0];
        state_next = ST_REV_C;
      end

      ST_REV_C: begin
        ram_we    = 1'b1;
        ram_waddr = hi[AW-1:0];
        ram_wdata = tmp;
        lo_next   = lo + ONE;
        hi_next   = hi - ONE;
        if ((lo + ONE) < (hi - ONE)) begin
          rd_issue   = 1'b1;
          ram_raddr  = AW'(lo + ONE);
          state_next = ST_REV_A;
        end else begin
          strobe_next = 1'b1;
          state_next  = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      strobe   <= 1'b0;
      rvalid   <= 1'b0;
      iss_done <= 1'b1;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      strobe   <= strobe_next;
      rvalid   <= rvalid_next;
      iss_done <= iss_done_next;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      key <= key_in;
      pos <= position;
    end
    op     <= op_next;
    fin    <= fin_next;
    ridx   <= ridx_next;
    dir_up <= dir_up_next;
    rtag   <= rtag_next;
    lo     <= lo_next;
    hi     <= hi_next;
    tmp    <= tmp_next;
    status <= status_next;
    index  <= index_next;
    data   <= data_next;
    last   <= last_next;
    count  <= cnt_next;
  end

  // the final result of a request leaves the block idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("final result while still busy");

  // a dump result that is not final keeps the walk going
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("partial result while idle");

  // list never grows past its capacity
  a_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= CAP)
    else $error("live count above capacity");

  // no read ever hits the entry written in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && rd_issue && (ram_waddr == ram_raddr)))
    else $error("read and write of one entry in one cycle");

  // a hit always names a live entry
  a_found_live: assert property (@(posedge clk) disable iff (rst)
    strobe && (status == STAT_FOUND) |-> (COUNT_W'(index) < count))
    else $error("found index outside the live part");

endmodule

### rtl/core/array_list_table_engine_unit.sv
`timescale 1ns / 1ps

// channel   direction  ports                                  handshake
// request   in         req_type, value, position              start && !busy
// result    out        status, index, data, last, count       strobe, one cycle
//
// one request at a time; the single read port of the entry memory sets the pace
// search, update and dump read the entries from the lowest up; insert and delete move the tail
// dump gives one result a cycle; reverse swaps the entries pairwise from both ends
// refusals, appends, tail deletes and empty tables answer in the cycle after start
// rst is synchronous and empties the list; memory contents are not cleared
// results cannot be stalled; the next start is taken while the last result shows

module array_list_table_engine_unit import altet_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [REQ_W-1:0]          req_type,
  input  logic signed [VALUE_W-1:0] value,
  input  logic [POS_W-1:0]          position,
  output logic                      strobe,
  output logic [STATUS_W-1:0]       status,
  output logic [INDEX_W-1:0]        index,
  output logic signed [VALUE_W-1:0] data,
  output logic                      last,
  output logic [COUNT_W-1:0]        count
);

  localparam int AW = $clog2(CAPACITY);

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  // request sequencer
  altet_seq #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req_type  (req_type),
    .value     (value),
    .position  (position),
    .busy      (busy),
    .strobe    (strobe),
    .status    (status),
    .index     (index),
    .data      (data),
    .last      (last),
    .count     (count),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // entry memory
  altet_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

### test/tb_array_list_table_engine_unit.sv
`timescale 1ns / 1ps

module tb_array_list_table_engine_unit;
  import altet_pkg::*;

  localparam int LIST_CAP    = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 120;
  localparam int PHASE_ITEMS = 8;

  // selector values the block has no operation for
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  typedef struct {
    logic [STATUS_W-1:0]       status;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] data;
    logic                      last;
    logic [COUNT_W-1:0]        count;
  } list_result_t;

  typedef struct {
    logic [REQ_W-1:0]          req;
    logic signed [VALUE_W-1:0] val;
    logic [POS_W-1:0]          pos;
    bit                        typed;
    logic [STATUS_W-1:0]       t_status;
    logic [INDEX_W-1:0]        t_index;
    logic [COUNT_W-1:0]        t_count;
  } directed_row_t;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic [REQ_W-1:0]          req_type;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          position;
  logic                      strobe;
  logic [STATUS_W-1:0]       status;
  logic [INDEX_W-1:0]        index;
  logic signed [VALUE_W-1:0] data;
  logic                      last;
  logic [COUNT_W-1:0]        count;

  // shadow copy of the list kept by the predictor
  logic signed [VALUE_W-1:0] shadow_list [LIST_CAP];
  int                        shadow_len;

  list_result_t  awaited_results [$];
  list_result_t  step_results [$];
  directed_row_t directed_rows [$];
  list_result_t  seen_expect;

  int err_cnt;
  int cycle_cnt;
  int idle_pct;

  array_list_table_engine_unit dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req_type (req_type),
    .value    (value),
    .position (position),
    .strobe   (strobe),
    .status   (status),
    .index    (index),
    .data     (data),
    .last     (last),
    .count    (count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one result record, count taken from the shadow length at this point
  function automatic void add_result(input logic [STATUS_W-1:0] st,
                                     input logic [INDEX_W-1:0] idx,
                                     input logic signed [VALUE_W-1:0] dat,
                                     input logic lst);
    list_result_t r;
    r.status = st;
    r.index  = idx;
    r.data   = dat;
    r.last   = lst;
    r.count  = shadow_len[COUNT_W-1:0];
    step_results.push_back(r);
  endfunction

  // list behavior: updates the shadow list and fills step_results
  function automatic void apply_list_request(input logic [REQ_W-1:0] req,
                                             input logic signed [VALUE_W-1:0] val,
                                             input logic [POS_W-1:0] pos);
    int                        hit_idx;
    int                        lo;
    int                        hi;
    logic signed [VALUE_W-1:0] tmp;
    hit_idx = -1;
    case (req)
      REQ_SEARCH: begin
        for (int i = 0; i < shadow_len; i++)
          if (hit_idx < 0 && shadow_list[i] == val) hit_idx = i;
        if (hit_idx >= 0) add_result(STAT_FOUND, hit_idx[INDEX_W-1:0], '0, 1'b1);
        else add_result(STAT_NOT_FOUND, '0, '0, 1'b1);
      end
      REQ_INSERT: begin
        if (int'(pos) > shadow_len) begin
          add_result(STAT_BAD_POS, '0, '0, 1'b1);
        end else if (shadow_len >= LIST_CAP) begin
          add_result(STAT_FULL, '0, '0, 1'b1);
        end else begin
          for (int i = shadow_len; i > int'(pos); i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[pos] = val;
          shadow_len++;
          add_result(STAT_DONE, '0, '0, 1'b1);
        end
      end
      REQ_DELETE: begin
        if (int'(pos) >= shadow_len) begin
          add_result(STAT_BAD_POS, '0, '0, 1'b1);
        end else begin
          for (int i = int'(pos); i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
          add_result(STAT_DONE, '0, '0, 1'b1);
        end
      end
      REQ_REVERSE: begin
        lo = 0;
        hi = shadow_len - 1;
        while (lo < hi) begin
          tmp             = shadow_list[lo];
          shadow_list[lo] = shadow_list[hi];
          shadow_list[hi] = tmp;
          lo++;
          hi--;
        end
        add_result(STAT_DONE, '0, '0, 1'b1);
      end
      REQ_UPDATE: begin
        // even slots gain 5, odd slots double, both wrap
        for (int i = 0; i < shadow_len; i++) begin
          if (i % 2 == 0) shadow_list[i] = shadow_list[i] + 32'sd5;
          else shadow_list[i] = shadow_list[i] <<< 1;
        end
        add_result(STAT_DONE, '0, '0, 1'b1);
      end
      REQ_DUMP: begin
        if (shadow_len == 0) add_result(STAT_EMPTY, '0, '0, 1'b1);
        else
          for (int i = 0; i < shadow_len; i++)
            add_result(STAT_DONE, i[INDEX_W-1:0], shadow_list[i], i + 1 == shadow_len);
      end
      default: add_result(STAT_DONE, '0, '0, 1'b1);
    endcase
  endfunction

  // present one item, wait for it to be taken, record what it should produce
  task automatic send_item(input logic [REQ_W-1:0] req,
                           input logic signed [VALUE_W-1:0] val,
                           input logic [POS_W-1:0] pos,
                           input bit typed,
                           input logic [STATUS_W-1:0] t_status,
                           input logic [INDEX_W-1:0] t_index,
                           input logic [COUNT_W-1:0] t_count);
    list_result_t typed_res;
    start    <= 1'b1;
    req_type <= req;
    value    <= val;
    position <= pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    step_results.delete();
    apply_list_request(req, val, pos);
    if (typed) begin
      typed_res.status = t_status;
      typed_res.index  = t_index;
      typed_res.data   = '0;
      typed_res.last   = 1'b1;
      typed_res.count  = t_count;
      awaited_results.push_back(typed_res);
    end else begin
      foreach (step_results[i]) awaited_results.push_back(step_results[i]);
    end
    // random sender gap
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // hold off the sender until every awaited result has shown up
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic [REQ_W-1:0] req,
                         input logic signed [VALUE_W-1:0] val,
                         input logic [POS_W-1:0] pos,
                         input bit typed,
                         input logic [STATUS_W-1:0] t_status,
                         input logic [INDEX_W-1:0] t_index,
                         input logic [COUNT_W-1:0] t_count);
    directed_row_t row;
    row.req      = req;
    row.val      = val;
    row.pos      = pos;
    row.typed    = typed;
    row.t_status = t_status;
    row.t_index  = t_index;
    row.t_count  = t_count;
    directed_rows.push_back(row);
  endtask

  // word mix biased toward the extremes
  function automatic logic signed [VALUE_W-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return -32'sd1;
      3: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // one random item, mostly well formed against the current list
  task automatic random_item();
    int                        pick;
    logic signed [VALUE_W-1:0] key;
    logic [POS_W-1:0]          pos;
    pick = $urandom_range(0, 99);
    key  = rand_word();
    pos  = POS_W'($urandom_range(0, LIST_CAP));
    if (pick < 30) begin
      if ($urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(0, shadow_len));
      send_item(REQ_INSERT, key, pos, 1'b0, '0, '0, '0);
    end else if (pick < 58) begin
      if (shadow_len > 0 && $urandom_range(0, 99) < 85)
        pos = POS_W'($urandom_range(0, shadow_len - 1));
      send_item(REQ_DELETE, key, pos, 1'b0, '0, '0, '0);
    end else if (pick < 73) begin
      if (shadow_len > 0 && $urandom_range(0, 99) < 60)
        key = shadow_list[$urandom_range(0, shadow_len - 1)];
      send_item(REQ_SEARCH, key, pos, 1'b0, '0, '0, '0);
    end else if (pick < 81) begin
      send_item(REQ_REVERSE, key, pos, 1'b0, '0, '0, '0);
    end else if (pick < 89) begin
      send_item(REQ_UPDATE, key, pos, 1'b0, '0, '0, '0);
    end else if (pick < 97) begin
      send_item(REQ_DUMP, key, pos, 1'b0, '0, '0, '0);
    end else begin
      send_item(REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)), key, pos,
                1'b0, '0, '0, '0);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: status %0d index %0d data %0d last %0d count %0d",
               status, index, data, last, count);
        err_cnt++;
      end else begin
        seen_expect = awaited_results.pop_front();
        if (status !== seen_expect.status) begin
          $error("status: expected %0d actual %0d", seen_expect.status, status);
          err_cnt++;
        end
        if (index !== seen_expect.index) begin
          $error("index: expected %0d actual %0d", seen_expect.index, index);
          err_cnt++;
        end
        if (data !== seen_expect.data) begin
          $error("data: expected %0d actual %0d", seen_expect.data, data);
          err_cnt++;
        end
        if (last !== seen_expect.last) begin
          $error("last: expected %0d actual %0d", seen_expect.last, last);
          err_cnt++;
        end
        if (count !== seen_expect.count) begin
          $error("count: expected %0d actual %0d", seen_expect.count, count);
          err_cnt++;
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int idle_plan [4];
    idle_plan  = '{0, 45, 0, 37};
    err_cnt    = 0;
    idle_pct   = 0;
    shadow_len = 0;
    rst        = 1'b1;
    start      = 1'b0;
    req_type   = REQ_SEARCH;
    value      = '0;
    position   = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table cases, extremes, bad positions, spare selectors
    add_row(REQ_DUMP,    32'sd0,       7'd0,  1'b1, STAT_EMPTY,     6'd0, 7'd0);
    add_row(REQ_SEARCH,  32'sd0,       7'd0,  1'b1, STAT_NOT_FOUND, 6'd0, 7'd0);
    add_row(REQ_DELETE,  32'sd0,       7'd0,  1'b1, STAT_BAD_POS,   6'd0, 7'd0);
    add_row(REQ_INSERT,  32'sd5,       7'd1,  1'b1, STAT_BAD_POS,   6'd0, 7'd0);
    add_row(REQ_REVERSE, 32'sd0,       7'd0,  1'b1, STAT_DONE,      6'd0, 7'd0);
    add_row(REQ_UPDATE,  32'sd0,       7'd0,  1'b1, STAT_DONE,      6'd0, 7'd0);
    add_row(REQ_INSERT,  32'sh7FFF_FFFF, 7'd0, 1'b1, STAT_DONE,     6'd0, 7'd1);
    add_row(REQ_INSERT,  32'sh8000_0000, 7'd1, 1'b1, STAT_DONE,     6'd0, 7'd2);
    add_row(REQ_INSERT,  -32'sd1,      7'd0,  1'b1, STAT_DONE,      6'd0, 7'd3);
    add_row(REQ_INSERT,  32'sd0,       7'd3,  1'b1, STAT_DONE,      6'd0, 7'd4);
    add_row(REQ_INSERT,  32'sd1,       7'd64, 1'b1, STAT_BAD_POS,   6'd0, 7'd4);
    add_row(REQ_SEARCH,  32'sh8000_0000, 7'd0, 1'b1, STAT_FOUND,    6'd2, 7'd4);
    add_row(REQ_SEARCH,  32'sd12345,   7'd0,  1'b1, STAT_NOT_FOUND, 6'd0, 7'd4);
    add_row(REQ_DUMP,    32'sd0,       7'd0,  1'b0, '0, '0, '0);
    add_row(REQ_UPDATE,  32'sd0,       7'd0,  1'b1, STAT_DONE,      6'd0, 7'd4);
    add_row(REQ_DUMP,    32'sd0,       7'd0,  1'b0, '0, '0, '0);
    add_row(REQ_REVERSE, 32'sd0,       7'd0,  1'b1, STAT_DONE,      6'd0, 7'd4);
    add_row(REQ_DUMP,    32'sd0,       7'd0,  1'b0, '0, '0, '0);
    add_row(REQ_SEARCH,  32'sd4,       7'd0,  1'b0, '0, '0, '0);
    add_row(REQ_DELETE,  32'sd0,       7'd4,  1'b1, STAT_BAD_POS,   6'd0, 7'd4);
    add_row(REQ_DELETE,  32'sd0,       7'd0,  1'b1, STAT_DONE,      6'd0, 7'd3);
    add_row(REQ_DELETE,  32'sd0,       7'd2,  1'b1, STAT_DONE,      6'd0, 7'd2);
    add_row(REQ_SPARE_LO, -32'sd1,     7'd64, 1'b1, STAT_DONE,      6'd0, 7'd2);
    add_row(REQ_SPARE_HI, 32'sd0,      7'd0,  1'b1, STAT_DONE,      6'd0, 7'd2);
    add_row(REQ_DUMP,    32'sd0,       7'd0,  1'b0, '0, '0, '0);
    foreach (directed_rows[i])
      send_item(directed_rows[i].req, directed_rows[i].val, directed_rows[i].pos,
                directed_rows[i].typed, directed_rows[i].t_status,
                directed_rows[i].t_index, directed_rows[i].t_count);
    drain_results();

    // random phases with different sender idling
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_plan[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) random_item();
      if (ph == 1) begin
        // fill to capacity, then work the full table
        while (shadow_len < LIST_CAP)
          send_item(REQ_INSERT, rand_word(), POS_W'($urandom_range(0, shadow_len)),
                    1'b0, '0, '0, '0);
        send_item(REQ_INSERT, rand_word(), 7'd64, 1'b0, '0, '0, '0);
        send_item(REQ_INSERT, rand_word(), 7'd0, 1'b0, '0, '0, '0);
        send_item(REQ_DUMP, 32'sd0, 7'd0, 1'b0, '0, '0, '0);
        send_item(REQ_SEARCH, shadow_list[LIST_CAP-1], 7'd0, 1'b0, '0, '0, '0);
        send_item(REQ_REVERSE, 32'sd0, 7'd0, 1'b0, '0, '0, '0);
        send_item(REQ_UPDATE, 32'sd0, 7'd0, 1'b0, '0, '0, '0);
        send_item(REQ_DUMP, 32'sd0, 7'd0, 1'b0, '0, '0, '0);
        send_item(REQ_DELETE, 32'sd0, 7'd64, 1'b0, '0, '0, '0);
        send_item(REQ_DELETE, 32'sd0, 7'd63, 1'b0, '0, '0, '0);
      end
      drain_results();
    end

    // let any stray result surface before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      err_cnt++;
    end
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
